// ===== hdl/rater_facets_gpcm_probabilities_defines.svh =====
// -----------------------------------------------------------------------------
// rater_facets_gpcm_probabilities_defines.svh
// Assertion macros shared by the probability block.
// -----------------------------------------------------------------------------
`ifndef RATER_FACETS_GPCM_PROBABILITIES_DEFINES_SVH
`define RATER_FACETS_GPCM_PROBABILITIES_DEFINES_SVH

// Concurrent check on an explicit clock and active-low reset.
`define RFG_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check on the block clock and reset.
`define RFG_ASSERT(lbl, prop, msg) \
  `RFG_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/rfg_pkg.sv =====
// -----------------------------------------------------------------------------
// rfg_pkg
// Shared constants, command codes, table port structs and fixed-point helpers.
// -----------------------------------------------------------------------------
package rfg_pkg;

  localparam int MAX_ITEMS_DEF  = 256;
  localparam int MAX_RATERS_DEF = 64;
  localparam int MAX_CATS_DEF   = 7;

  // Index fields sized for the largest supported tables
  localparam int ITEM_IDX_W  = 12;
  localparam int RATER_IDX_W = 10;
  localparam int SLOT_IDX_W  = 6;
  localparam int WORD_W      = 24;

  localparam logic [2:0]  NUM_CATS_RST = 3'd3;
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;
  localparam logic [16:0] ONE_Q16      = 17'd65536;

  typedef enum logic [2:0] {
    FN_LD_THR   = 3'd0,
    FN_LD_LOAD  = 3'd1,
    FN_LD_IDISC = 3'd2,
    FN_LD_RSEV  = 3'd3,
    FN_LD_RDISC = 3'd4,
    FN_COMPUTE  = 3'd5
  } func_e;

  typedef struct packed {
    logic                    thr_we;
    logic                    load_we;
    logic                    idisc_we;
    logic                    rsev_we;
    logic                    rdisc_we;
    logic [ITEM_IDX_W-1:0]   item;
    logic [RATER_IDX_W-1:0]  rater;
    logic [SLOT_IDX_W-1:0]   slot;
    logic [WORD_W-1:0]       data;
  } tbl_wr_t;

  typedef struct packed {
    logic                    head_re;
    logic                    cat_re;
    logic [ITEM_IDX_W-1:0]   item;
    logic [RATER_IDX_W-1:0]  rater;
    logic [SLOT_IDX_W-1:0]   slot;
  } tbl_rd_t;

  typedef logic [15:0][29:0] root_tab_t;

  function automatic logic signed [31:0] sat32w(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q.16 product, rounded half away from zero, saturated to 32 bits
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0]        m;
    logic [47:0]        r;
    logic signed [47:0] s;
    p = 64'(a) * 64'(b);
    m = (p < 0) ? 64'(-p) : 64'(p);
    r = 48'((m + 64'd32768) >> 16);
    s = (p < 0) ? -$signed(r) : $signed(r);
    return sat32w(s);
  endfunction

  function automatic logic [63:0] isqrt_round(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] res;
    logic [63:0] bt;
    xr  = x;
    res = 64'd0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (xr >= res + bt) begin
        xr  = xr - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return (xr > res) ? res + 64'd1 : res;
  endfunction

  // Q.30 constants 2^(-2^-j), j = 1..16, held at index j-1
  function automatic root_tab_t build_roots();
    logic [63:0] prev;
    root_tab_t   tab;
    prev = 64'd1 << 29;
    for (int j = 0; j < 16; j++) begin
      prev   = isqrt_round(prev << 30);
      tab[j] = prev[29:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// ===== hdl/rfg_tables.sv =====
// -----------------------------------------------------------------------------
// rfg_tables
// Item and rater parameter memories: one write port, registered reads.
// -----------------------------------------------------------------------------
module rfg_tables import rfg_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int MAX_RATERS = MAX_RATERS_DEF,
  parameter int MAX_CATS   = MAX_CATS_DEF
) (
  input  logic                     clk_i,
  input  tbl_wr_t                  wr_i,
  input  tbl_rd_t                  rd_i,
  output logic signed [WORD_W-1:0] thr_o,
  output logic signed [WORD_W-1:0] load_o,
  output logic signed [WORD_W-1:0] idisc_o,
  output logic signed [WORD_W-1:0] rsev_o,
  output logic signed [WORD_W-1:0] rdisc_o
);

  localparam int IAW       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int RAW       = (MAX_RATERS > 1) ? $clog2(MAX_RATERS) : 1;
  localparam int SW        = (MAX_CATS > 1) ? $clog2(MAX_CATS) : 1;
  localparam int CAT_DEPTH = MAX_ITEMS * (2 ** SW);

  logic [WORD_W-1:0] thr_mem   [CAT_DEPTH];
  logic [WORD_W-1:0] load_mem  [CAT_DEPTH];
  logic [WORD_W-1:0] idisc_mem [MAX_ITEMS];
  logic [WORD_W-1:0] rsev_mem  [MAX_RATERS];
  logic [WORD_W-1:0] rdisc_mem [MAX_RATERS];

  logic [IAW+SW-1:0] wa;
  logic [IAW+SW-1:0] ra;

  assign wa = {wr_i.item[IAW-1:0], wr_i.slot[SW-1:0]};
  assign ra = {rd_i.item[IAW-1:0], rd_i.slot[SW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_i.thr_we) begin
      thr_mem[wa] <= wr_i.data;
    end
    if (wr_i.load_we) begin
      load_mem[wa] <= wr_i.data;
    end
    if (wr_i.idisc_we) begin
      idisc_mem[wr_i.item[IAW-1:0]] <= wr_i.data;
    end
    if (wr_i.rsev_we) begin
      rsev_mem[wr_i.rater[RAW-1:0]] <= wr_i.data;
    end
    if (wr_i.rdisc_we) begin
      rdisc_mem[wr_i.rater[RAW-1:0]] <= wr_i.data;
    end
  end

  // Hold read data until the next read of the same group
  always_ff @(posedge clk_i) begin
    if (rd_i.cat_re) begin
      thr_o  <= thr_mem[ra];
      load_o <= load_mem[ra];
    end
    if (rd_i.head_re) begin
      idisc_o <= idisc_mem[rd_i.item[IAW-1:0]];
      rsev_o  <= rsev_mem[rd_i.rater[RAW-1:0]];
      rdisc_o <= rdisc_mem[rd_i.rater[RAW-1:0]];
    end
  end

endmodule

// ===== hdl/rater_facets_gpcm_probabilities.sv =====
// -----------------------------------------------------------------------------
// rater_facets_gpcm_probabilities
// Operation: a table load returns no result. A compute with K categories keeps
//   busy high through its last divider step; results 0..K leave from the
//   bit-serial divider, one per strobe.
// Throughput: one compute at a time; the shared exponent multiplier (16 steps)
//   and the restoring divider (17 steps) run once per category each.
// Reset: control and num_categories (to 3) clear at once; tables are unset.
// -----------------------------------------------------------------------------
`include "rater_facets_gpcm_probabilities_defines.svh"

module rater_facets_gpcm_probabilities import rfg_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int MAX_RATERS = MAX_RATERS_DEF,
  parameter int MAX_CATS   = MAX_CATS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic [2:0]         func_i,
  input  logic [7:0]         item_i,
  input  logic [5:0]         rater_i,
  input  logic [2:0]         category_i,
  input  logic signed [23:0] value_i,
  output logic               valid_o,
  output logic [2:0]         out_category_o,
  output logic [16:0]        probability_o,
  output logic               last_o
);

  localparam int IAW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int RAW = (MAX_RATERS > 1) ? $clog2(MAX_RATERS) : 1;
  localparam logic [2:0] KMAX = (MAX_CATS > 7) ? 3'd7 : 3'(MAX_CATS);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_HDR   = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_MUL2  = 4'd4;
  localparam logic [3:0] ST_LOGIT = 4'd5;
  localparam logic [3:0] ST_EXPT  = 4'd6;
  localparam logic [3:0] ST_EXPI  = 4'd7;
  localparam logic [3:0] ST_EXPF  = 4'd8;
  localparam logic [3:0] ST_DIVI  = 4'd9;
  localparam logic [3:0] ST_DIVS  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] ncat_q;
  logic [2:0] kk_q;
  logic [2:0] kc_q;
  logic [3:0] jc_q;
  logic [4:0] step_q;

  logic [IAW-1:0]     it_q;
  logic signed [23:0] th_q;
  logic signed [31:0] sa_q, p1_q, p2_q, slope_q, b_q, mx_q;
  logic signed [31:0] lg_q [8];
  logic [16:0]        e_q [8];
  logic [19:0]        sum_q;
  logic               flush_q;
  logic [4:0]         sh_q;
  logic [15:0]        f_q;
  logic [30:0]        acc_q;
  logic [19:0]        rem_q;
  logic [16:0]        nlo_q;
  logic [16:0]        quo_q;
  logic               valid_q, last_q;
  logic [2:0]         ocat_q;
  logic [16:0]        prob_q;

  logic               accept, compute_go, slot_ok;
  logic [IAW-1:0]     it_in;
  logic [RAW-1:0]     ra_in;
  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;
  logic signed [23:0] thr, load, idisc, rsev, rdisc;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign compute_go = accept && (func_i == FN_COMPUTE);
  assign it_in      = IAW'(item_i % MAX_ITEMS);
  assign ra_in      = RAW'(rater_i % MAX_RATERS);
  assign slot_ok    = int'(category_i) < MAX_CATS;

  // Table writes land at the accept edge; busy keeps them clear of computes
  always_comb begin
    tbl_wr          = '0;
    tbl_wr.thr_we   = accept && (func_i == FN_LD_THR) && slot_ok;
    tbl_wr.load_we  = accept && (func_i == FN_LD_LOAD) && slot_ok;
    tbl_wr.idisc_we = accept && (func_i == FN_LD_IDISC);
    tbl_wr.rsev_we  = accept && (func_i == FN_LD_RSEV);
    tbl_wr.rdisc_we = accept && (func_i == FN_LD_RDISC);
    tbl_wr.item     = ITEM_IDX_W'(it_in);
    tbl_wr.rater    = RATER_IDX_W'(ra_in);
    tbl_wr.slot     = SLOT_IDX_W'(category_i);
    tbl_wr.data     = value_i;
  end

  // Head words are fetched with the accept; category k fetches slot k-1
  always_comb begin
    tbl_rd         = '0;
    tbl_rd.head_re = compute_go;
    tbl_rd.cat_re  = (state_q == ST_RD);
    tbl_rd.item    = busy ? ITEM_IDX_W'(it_q) : ITEM_IDX_W'(it_in);
    tbl_rd.rater   = RATER_IDX_W'(ra_in);
    tbl_rd.slot    = SLOT_IDX_W'(kc_q - 3'd1);
  end

  rfg_tables #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_RATERS (MAX_RATERS),
    .MAX_CATS   (MAX_CATS)
  ) u_tables (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .rd_i    (tbl_rd),
    .thr_o   (thr),
    .load_o  (load),
    .idisc_o (idisc),
    .rsev_o  (rsev),
    .rdisc_o (rdisc)
  );

  // ---------------------------------------------------------------------------
  // Datapath terms, one multiplier between registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] sa_c, p1_c, p2_c, slope_c, b_c, lg_c;
  logic signed [32:0] d_c;
  logic [32:0]        u_c;
  logic [33:0]        t_c;
  logic [17:0]        n_c;
  logic [60:0]        prod_c;
  logic [30:0]        acc_n;
  logic [16:0]        e_c;
  logic [33:0]        num_c;
  logic [20:0]        r2_c, rem_n;
  logic               ge_c;

  assign sa_c    = mulq(32'(idisc), 32'(rdisc));
  assign p1_c    = mulq(sa_q, 32'(load));
  assign p2_c    = mulq(32'(rsev), 32'(load));
  assign slope_c = mulq(p1_q, 32'(th_q));
  assign b_c     = sat32w(48'(thr) + 48'(p2_q));
  assign lg_c    = sat32w(48'(slope_q) - 48'(b_q));

  // Distance below the largest logit, scaled to base 2
  assign d_c = 33'(mx_q) - 33'(lg_q[kc_q]);
  assign u_c = $unsigned(d_c);
  assign t_c = 34'((51'(u_c) * 51'(LOG2E_Q16) + 51'd32768) >> 16);
  assign n_c = t_c[33:16];

  // One root factor per step, taken from the top bit of the fraction down
  assign prod_c = 61'(acc_q) * 61'(ROOT_TAB[jc_q]);
  assign acc_n  = 31'((prod_c + 61'h2000_0000) >> 30);

  assign e_c = flush_q ? 17'd0
                       : 17'((32'(acc_q) + (32'd1 << (sh_q - 5'd1))) >> sh_q);

  // Rounded quotient e*2^16 / sum, one bit per step
  assign num_c = 34'({e_q[kc_q], 16'h0000}) + 34'(sum_q[19:1]);
  assign r2_c  = {rem_q, nlo_q[16]};
  assign ge_c  = (r2_c >= 21'(sum_q));
  assign rem_n = ge_c ? (r2_c - 21'(sum_q)) : r2_c;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (compute_go) state_d = ST_HDR;
      ST_HDR:   state_d = (kk_q == 3'd0) ? ST_EXPT : ST_RD;
      ST_RD:    state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_LOGIT;
      ST_LOGIT: state_d = (kc_q == kk_q) ? ST_EXPT : ST_RD;
      ST_EXPT:  state_d = ST_EXPI;
      ST_EXPI:  if (jc_q == 4'd15) state_d = ST_EXPF;
      ST_EXPF:  state_d = (kc_q == kk_q) ? ST_DIVI : ST_EXPT;
      ST_DIVI:  state_d = ST_DIVS;
      ST_DIVS: begin
        if (step_q == 5'd16) begin
          state_d = (kc_q == kk_q) ? ST_IDLE : ST_DIVI;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ncat_q  <= NUM_CATS_RST;
      kk_q    <= 3'd0;
      kc_q    <= 3'd0;
      jc_q    <= 4'd0;
      step_q  <= 5'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Strobe on the last divider step of each category
      valid_q <= (state_q == ST_DIVS) && (step_q == 5'd16);
      if (cfg_we_i) begin
        ncat_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (compute_go) begin
            kk_q <= (ncat_q > KMAX) ? KMAX : ncat_q;
            kc_q <= 3'd0;
          end
        end
        ST_HDR:   kc_q <= (kk_q == 3'd0) ? 3'd0 : 3'd1;
        ST_LOGIT: kc_q <= (kc_q == kk_q) ? 3'd0 : kc_q + 3'd1;
        ST_EXPT:  jc_q <= 4'd0;
        ST_EXPI:  jc_q <= jc_q + 4'd1;
        ST_EXPF:  kc_q <= (kc_q == kk_q) ? 3'd0 : kc_q + 3'd1;
        ST_DIVI:  step_q <= 5'd0;
        ST_DIVS: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd16) begin
            kc_q <= (kc_q == kk_q) ? 3'd0 : kc_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (compute_go) begin
          it_q     <= it_in;
          th_q     <= value_i;
          mx_q     <= 32'sd0;
          lg_q[0]  <= 32'sd0;
          sum_q    <= 20'd0;
        end
      end
      ST_HDR:  sa_q <= sa_c;
      ST_MUL1: begin
        p1_q <= p1_c;
        p2_q <= p2_c;
      end
      ST_MUL2: begin
        slope_q <= slope_c;
        b_q     <= b_c;
      end
      ST_LOGIT: begin
        lg_q[kc_q] <= lg_c;
        if (lg_c > mx_q) begin
          mx_q <= lg_c;
        end
      end
      ST_EXPT: begin
        flush_q <= (n_c > 18'd16);
        sh_q    <= 5'(n_c) + 5'd14;
        f_q     <= t_c[15:0];
        acc_q   <= 31'h4000_0000;
      end
      ST_EXPI: begin
        if (f_q[~jc_q]) begin
          acc_q <= acc_n;
        end
      end
      ST_EXPF: begin
        e_q[kc_q] <= e_c;
        sum_q     <= sum_q + 20'(e_c);
      end
      ST_DIVI: begin
        rem_q <= 20'(num_c[33:17]);
        nlo_q <= num_c[16:0];
      end
      ST_DIVS: begin
        rem_q <= rem_n[19:0];
        nlo_q <= {nlo_q[15:0], 1'b0};
        quo_q <= {quo_q[15:0], ge_c};
        if (step_q == 5'd16) begin
          prob_q <= {quo_q[15:0], ge_c};
          ocat_q <= kc_q;
          last_q <= (kc_q == kk_q);
        end
      end
      default: ;
    endcase
  end

  assign valid_o        = valid_q;
  assign out_category_o = ocat_q;
  assign probability_o  = prob_q;
  assign last_o         = last_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `RFG_ASSERT(a_strobe_single, valid_o |=> !valid_o, "result strobe lasted two cycles")
  `RFG_ASSERT(a_cat_bound, valid_o |-> out_category_o <= kk_q, "category beyond K")
  `RFG_ASSERT(a_last_on_k, valid_o && last_o |-> out_category_o == kk_q, "last not on K")
  `RFG_ASSERT(a_compute_busy, compute_go |=> busy, "compute accepted without busy")
  `RFG_ASSERT(a_sum_floor, state_q == ST_DIVS |-> sum_q >= 20'(ONE_Q16), "sum below one")

endmodule

// ===== tb/sv/rater_facets_gpcm_probabilities_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rater_facets_gpcm_probabilities_checker
// Watches the command and result ports, keeps its own copy of the tables and
// the category count, and predicts and compares every probability.
// ----------------------------------------------------------------------------
module rater_facets_gpcm_probabilities_checker import rfg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic [2:0]         func_i,
  input  logic [7:0]         item_i,
  input  logic [5:0]         rater_i,
  input  logic [2:0]         category_i,
  input  logic signed [23:0] value_i,
  input  logic               valid_o,
  input  logic [2:0]         out_category_o,
  input  logic [16:0]        probability_o,
  input  logic               last_o,
  output int                 pending_o,
  output int                 fail_o,
  output int                 results_o
);

  localparam int NCAT = 7;

  typedef struct {
    logic [2:0]  category;
    logic [16:0] prob;
    logic        last;
  } prob_result_t;

  prob_result_t prob_queue[$];

  logic signed [23:0] thr_tab [0:256*NCAT-1];
  logic signed [23:0] ldg_tab [0:256*NCAT-1];
  logic signed [23:0] idisc_tab [0:255];
  logic signed [23:0] rsev_tab [0:63];
  logic signed [23:0] rdisc_tab [0:63];
  logic [2:0]         num_cat;
  longint unsigned    half_roots [1:16];

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? longint'(-p) : longint'(p);
    m = (m + 64'd32768) >> 16;
    return sat_word((p < 0) ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint unsigned nearest_sqrt(longint unsigned x);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= x) r = c;
    end
    return (x - r * r > r) ? r + 1 : r;
  endfunction

  // e^z for z <= 0, Q1.16 out, via base-2 split into shift and root products
  function automatic longint unsigned exp_q16(longint z);
    longint unsigned u, t, n, f, acc;
    int sh;
    u = longint'(-z);
    t = (u * 64'd94548 + 64'd32768) >> 16;
    n = t >> 16;
    f = t & 64'hFFFF;
    if (n >= 17) return 0;
    acc = 64'd1 << 30;
    for (int j = 1; j <= 16; j++)
      if ((f >> (16 - j)) & 1)
        acc = (acc * half_roots[j] + (64'd1 << 29)) >> 30;
    sh = 14 + int'(n);
    return (acc + (64'd1 << (sh - 1))) >> sh;
  endfunction

  task automatic predict_probabilities(int it, int ra, longint theta);
    longint logit [0:NCAT];
    longint unsigned e [0:NCAT];
    longint unsigned total;
    longint mx, sa, q, slope, offs;
    int kk;
    prob_result_t r;
    kk = num_cat;
    if (kk > NCAT) kk = NCAT;
    sa = q16_mul(idisc_tab[it], rdisc_tab[ra]);
    logit[0] = 0;
    mx = 0;
    for (int k = 1; k <= kk; k++) begin
      q = ldg_tab[it*NCAT + k - 1];
      slope = q16_mul(q16_mul(sa, q), theta);
      offs = sat_word(longint'(thr_tab[it*NCAT + k - 1]) + q16_mul(rsev_tab[ra], q));
      logit[k] = sat_word(slope - offs);
      if (logit[k] > mx) mx = logit[k];
    end
    total = 0;
    for (int k = 0; k <= kk; k++) begin
      e[k] = exp_q16(logit[k] - mx);
      total += e[k];
    end
    for (int k = 0; k <= kk; k++) begin
      r.category = k[2:0];
      r.prob = 17'((e[k] * 64'd65536 + total / 2) / total);
      r.last = (k == kk);
      prob_queue.push_back(r);
    end
  endtask

  initial begin
    longint unsigned prev;
    prev = 64'd1 << 29;
    for (int j = 1; j <= 16; j++) begin
      prev = nearest_sqrt(prev << 30);
      half_roots[j] = prev;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    prob_result_t exp_r;
    if (!rst_ni) begin
      num_cat <= NUM_CATS_RST;
      prob_queue.delete();
      fail_o = 0;
      results_o = 0;
    end else begin
      // compare the result leaving this cycle against the oldest prediction
      if (valid_o) begin
        results_o++;
        if (prob_queue.size() == 0) begin
          $error("unexpected result: category %0d probability %0d",
                 out_category_o, probability_o);
          fail_o++;
        end else begin
          exp_r = prob_queue.pop_front();
          if (out_category_o !== exp_r.category) begin
            $error("out_category: expected %0d, actual %0d", exp_r.category,
                   out_category_o);
            fail_o++;
          end
          if (probability_o !== exp_r.prob) begin
            $error("probability: expected %0d, actual %0d", exp_r.prob,
                   probability_o);
            fail_o++;
          end
          if (last_o !== exp_r.last) begin
            $error("last: expected %0d, actual %0d", exp_r.last, last_o);
            fail_o++;
          end
        end
      end
      if (cfg_we_i) num_cat <= cfg_wdata_i;
      if (start && !busy) begin
        case (func_i)
          FN_LD_THR:   if (category_i < NCAT) thr_tab[item_i*NCAT + category_i] <= value_i;
          FN_LD_LOAD:  if (category_i < NCAT) ldg_tab[item_i*NCAT + category_i] <= value_i;
          FN_LD_IDISC: idisc_tab[item_i] <= value_i;
          FN_LD_RSEV:  rsev_tab[rater_i] <= value_i;
          FN_LD_RDISC: rdisc_tab[rater_i] <= value_i;
          FN_COMPUTE:  predict_probabilities(item_i, rater_i, longint'(value_i));
          default: ;
        endcase
      end
    end
    pending_o = prob_queue.size();
  end

endmodule

// ===== tb/sv/rater_facets_gpcm_probabilities_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rater_facets_gpcm_probabilities_test
// Loads item and rater tables, runs probability computes over several
// category counts with random sender gaps, and lets the checker compare.
// ----------------------------------------------------------------------------
module rater_facets_gpcm_probabilities_test;
  import rfg_pkg::*;

  // func codes the block ignores
  localparam logic [2:0] FN_SPARE_A = 3'd6;
  localparam logic [2:0] FN_SPARE_B = 3'd7;
  localparam int         NCAT       = 7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_wdata_i = '0;
  logic [2:0]         func_i = FN_COMPUTE;
  logic [7:0]         item_i = '0;
  logic [5:0]         rater_i = '0;
  logic [2:0]         category_i = '0;
  logic signed [23:0] value_i = '0;
  logic               valid_o;
  logic [2:0]         out_category_o;
  logic [16:0]        probability_o;
  logic               last_o;
  int                 pending, fails, results;

  // tables written so far; a compute only ever names fully written entries
  bit thr_set [0:255][0:NCAT-1];
  bit ldg_set [0:255][0:NCAT-1];
  bit idisc_set [0:255];
  bit item_ok [0:255];
  bit rsev_set [0:63];
  bit rdisc_set [0:63];
  bit rater_ok [0:63];
  int ready_items[$];
  int ready_raters[$];
  int idle_pct = 0;
  int n_items = 0;
  int n_computes = 0;
  bit [7:0] k_seen = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rater_facets_gpcm_probabilities uut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i, .func_i,
    .item_i, .rater_i, .category_i, .value_i, .valid_o, .out_category_o,
    .probability_o, .last_o
  );

  rater_facets_gpcm_probabilities_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i, .func_i,
    .item_i, .rater_i, .category_i, .value_i, .valid_o, .out_category_o,
    .probability_o, .last_o, .pending_o(pending), .fail_o(fails),
    .results_o(results)
  );

  // Track which table entries hold data so computes stay on written entries.
  function automatic void note_load(logic [2:0] f, int it, int ra, int cat);
    case (f)
      FN_LD_THR:   if (cat < NCAT) thr_set[it][cat] = 1'b1;
      FN_LD_LOAD:  if (cat < NCAT) ldg_set[it][cat] = 1'b1;
      FN_LD_IDISC: idisc_set[it] = 1'b1;
      FN_LD_RSEV:  rsev_set[ra] = 1'b1;
      FN_LD_RDISC: rdisc_set[ra] = 1'b1;
      default: ;
    endcase
    if (!item_ok[it] && idisc_set[it]) begin
      item_ok[it] = 1'b1;
      for (int c = 0; c < NCAT; c++)
        if (!thr_set[it][c] || !ldg_set[it][c]) item_ok[it] = 1'b0;
      if (item_ok[it]) ready_items.push_back(it);
    end
    if (!rater_ok[ra] && rsev_set[ra] && rdisc_set[ra]) begin
      rater_ok[ra] = 1'b1;
      ready_raters.push_back(ra);
    end
  endfunction

  // Present one item, idling first at the current rate, and hold it until
  // the block takes it (start high and busy low at the edge).
  task automatic send_item(logic [2:0] f, int it, int ra, int cat, logic [23:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= f;
    item_i     <= it[7:0];
    rater_i    <= ra[5:0];
    category_i <= cat[2:0];
    value_i    <= v;
    do @(posedge clk_i); while (busy);
    note_load(f, it, ra, cat);
    n_items++;
    if (f == FN_COMPUTE) n_computes++;
  endtask

  // Drop start and wait until every predicted result has come out.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_num_cats(logic [2:0] k);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_seen[k] = 1'b1;
  endtask

  // Mostly small Q8.16 words for meaningful spreads, plus full range and extremes.
  function automatic logic [23:0] table_word();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 24'($signed($urandom_range(262144)) - 131072);
    if (r < 90) return 24'($urandom);
    return r[0] ? 24'h7FFFFF : 24'h800000;
  endfunction

  task automatic fill_item(int it);
    for (int c = 0; c < NCAT; c++) begin
      send_item(FN_LD_THR, it, $urandom_range(63), c, table_word());
      send_item(FN_LD_LOAD, it, $urandom_range(63), c, table_word());
    end
    send_item(FN_LD_IDISC, it, $urandom_range(63), $urandom_range(7), table_word());
  endtask

  task automatic fill_rater(int ra);
    send_item(FN_LD_RSEV, $urandom_range(255), ra, $urandom_range(7), table_word());
    send_item(FN_LD_RDISC, $urandom_range(255), ra, $urandom_range(7), table_word());
  endtask

  task automatic random_compute();
    send_item(FN_COMPUTE, ready_items[$urandom_range(ready_items.size() - 1)],
              ready_raters[$urandom_range(ready_raters.size() - 1)],
              $urandom_range(7), table_word());
  endtask

  task automatic random_segment(int count, int pct, logic [2:0] k, bit mid_pause);
    int r;
    write_num_cats(k);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (mid_pause && i == count / 2) drain();
      if (r < 55) begin
        random_compute();
      end else if (r < 88) begin
        send_item(3'($urandom_range(4)), $urandom_range(255), $urandom_range(63),
                  $urandom_range(7), table_word());
      end else if (r < 94) begin
        send_item(r[0] ? FN_SPARE_A : FN_SPARE_B, $urandom_range(255),
                  $urandom_range(63), $urandom_range(7), 24'($urandom));
      end else begin
        // well-formed setup of a fresh item and rater, then use them
        fill_item($urandom_range(255));
        fill_rater($urandom_range(63));
        random_compute();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: top item and rater indexes, all categories, extreme thetas.
    write_num_cats(3'd7);
    fill_item(255);
    fill_rater(63);
    send_item(FN_COMPUTE, 255, 63, 0, 24'h7FFFFF);
    send_item(FN_COMPUTE, 255, 63, 0, 24'h800000);
    send_item(FN_COMPUTE, 255, 63, 0, 24'h000000);
    // slot beyond the table and spare codes are ignored
    send_item(FN_LD_THR, 255, 63, 7, 24'h123456);
    send_item(FN_SPARE_A, 0, 0, 0, 24'h0);
    send_item(FN_SPARE_B, 255, 63, 7, 24'hFFFFFF);
    write_num_cats(3'd0);
    send_item(FN_COMPUTE, 255, 63, 0, 24'h010000);
    write_num_cats(3'd1);
    send_item(FN_COMPUTE, 255, 63, 0, 24'hFF0000);

    // Random: sender idles 34%, then 77%, then never, over several K values.
    fill_item(0);
    fill_rater(0);
    random_segment(25, 34, 3'd2, 1'b0);
    random_segment(25, 77, 3'd7, 1'b1);
    random_segment(20, 0, 3'($urandom_range(3, 6)), 1'b0);
    random_segment(20, 0, 3'd1, 1'b0);

    drain();
    repeat (400) @(posedge clk_i);
    $display("Sent %0d items, %0d computes, checked %0d probabilities.",
             n_items, n_computes, results);
    $display("Category counts used (bit per K): %b", k_seen);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rfg_pkg.sv
hdl/rfg_tables.sv
hdl/rater_facets_gpcm_probabilities.sv
tb/sv/rater_facets_gpcm_probabilities_checker.sv
tb/sv/rater_facets_gpcm_probabilities_test.sv
